### sv/swr_pkg.sv
package swr_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int DELAY_BITS  = 10;
  localparam int CFG_BITS    = 11;
  localparam int RMS_BITS    = 16;
  localparam int STEP_BITS   = 8;
  localparam logic [CFG_BITS-1:0] WINDOW_RESET = CFG_BITS'(600);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic        [DELAY_BITS-1:0]  delay;
  } in_item_t;

  typedef struct packed {
    logic        [RMS_BITS-1:0]    rms_value;
    logic signed [SAMPLE_BITS-1:0] delayed_sample;
  } out_item_t;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } iter_op_t;

  typedef struct packed {
    logic                 start;
    iter_op_t             op;
    logic [STEP_BITS-1:0] steps;
  } iter_ctl_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SQ_OLD,
    S_SUB,
    S_ADD,
    S_DDIV,
    S_IDX,
    S_MDIV,
    S_SQRT,
    S_DONE
  } swr_state_t;

endpackage

### sv/swr_ram.sv
module swr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/swr_iter.sv
module swr_iter #(
  parameter int XW = 42,
  parameter int LW = 11,
  parameter int AW = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  swr_pkg::iter_ctl_t ctl,
  input  logic [XW-1:0]      num,
  input  logic [LW-1:0]      den,
  output logic               done,
  output logic [XW-1:0]      quot,
  output logic [LW-1:0]      rem
);

  import swr_pkg::*;

  logic                 busy;
  logic [STEP_BITS-1:0] count;
  iter_op_t             op;
  logic [XW-1:0]        x;
  logic [AW-1:0]        acc;
  logic [XW-1:0]        q;
  logic [AW-1:0]        a;
  logic [AW-1:0]        b;
  logic [AW:0]          diff;
  logic                 ge;

  // shared compare and subtract: restoring divide or digit-by-digit root
  always_comb begin
    if (op == OP_DIV) begin
      a = {acc[AW-2:0], x[XW-1]};
      b = AW'(den);
    end else begin
      a = {acc[AW-3:0], x[XW-1:XW-2]};
      b = {q[AW-3:0], 2'b01};
    end
    diff = {1'b0, a} - {1'b0, b};
    ge   = !diff[AW];
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= busy && (count == STEP_BITS'(1));
      if (ctl.start) begin
        busy  <= 1'b1;
        count <= ctl.steps;
      end else if (busy) begin
        count <= count - STEP_BITS'(1);
        if (count == STEP_BITS'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // one bit of quotient or root per cycle
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      op  <= ctl.op;
      x   <= num;
      acc <= '0;
      q   <= '0;
    end else if (busy) begin
      acc <= ge ? diff[AW-1:0] : a;
      q   <= {q[XW-2:0], ge};
      x   <= (op == OP_DIV) ? (x << 1) : (x << 2);
    end
  end

  assign quot = q;
  assign rem  = acc[LW-1:0];

endmodule

### sv/sliding_window_rms.sv
// item sequence: square the old ring entry and subtract it, add the square of the new sample,
// then the shared divide/root unit runs DELAY_BITS steps for the delay modulo, XW steps for
// the mean and XW/2 steps for the root, one bit per cycle
// flow: one item at a time; the next is taken only once the result has entered the output register
// reset: synchronous; after reset all MAX_WINDOW ring entries are zeroed before
// the first item is taken, window_len returns to 600, position and sum to zero
module sliding_window_rms #(
  parameter int MAX_WINDOW = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  swr_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output swr_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [swr_pkg::CFG_BITS-1:0]    cfg_data
);

  import swr_pkg::*;

  localparam int PW    = $clog2(MAX_WINDOW);
  localparam int LW    = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = 2 * SAMPLE_BITS + PW;
  localparam int XW    = SUM_W + (SUM_W % 2);
  localparam int RW    = XW / 2;
  localparam int AW    = ((LW + 1) > (RW + 3)) ? (LW + 1) : (RW + 3);
  localparam int SQ_W  = 2 * SAMPLE_BITS;

  swr_state_t state, state_next;

  logic [CFG_BITS-1:0]           window_len;
  logic [PW-1:0]                 clr_cnt;
  logic [PW-1:0]                 pos;
  logic [SUM_W-1:0]              sum;
  logic [SQ_W-1:0]               prod;
  in_item_t                      cur;
  logic [LW-1:0]                 len;
  logic [LW-1:0]                 len_eff;
  logic [LW-1:0]                 dr;
  logic [LW-1:0]                 pos_inc;
  logic [PW-1:0]                 pos_wrap;
  logic [LW:0]                   idx_t;
  logic [LW:0]                   idx_full;
  logic [PW-1:0]                 idx;
  logic signed [SAMPLE_BITS-1:0] mul_in;
  logic signed [SQ_W-1:0]        sq_full;
  logic [RW-1:0]                 root;
  logic [RW-1:0]                 root_sat;

  logic                          ram_we;
  logic [PW-1:0]                 ram_waddr;
  logic [SAMPLE_BITS-1:0]        ram_wdata;
  logic                          ram_re;
  logic [PW-1:0]                 ram_raddr;
  logic [SAMPLE_BITS-1:0]        ram_rdata;

  iter_ctl_t                     ctl;
  logic [XW-1:0]                 it_num;
  logic                          it_done;
  logic [XW-1:0]                 it_quot;
  logic [LW-1:0]                 it_rem;

  // window length clamped to 1..MAX_WINDOW
  always_comb begin
    if (window_len == '0) begin
      len_eff = LW'(1);
    end else if (32'(window_len) > MAX_WINDOW) begin
      len_eff = LW'(MAX_WINDOW);
    end else begin
      len_eff = LW'(window_len);
    end
  end

  // write position advance and delayed read index
  always_comb begin
    pos_inc  = LW'(pos) + LW'(1);
    pos_wrap = (pos_inc >= len) ? '0 : pos_inc[PW-1:0];
    idx_t    = (LW + 1)'(pos) + (LW + 1)'(len) - (LW + 1)'(1) - (LW + 1)'(dr);
    idx_full = (idx_t >= (LW + 1)'(len)) ? (idx_t - (LW + 1)'(len)) : idx_t;
    idx      = idx_full[PW-1:0];
  end

  // shared squarer, old entry first, then the new sample
  assign mul_in  = (state == S_SQ_OLD) ? $signed(ram_rdata) : cur.sample;
  assign sq_full = mul_in * mul_in;

  // root saturation
  assign root     = it_quot[RW-1:0];
  assign root_sat = (root > RW'(2 ** (SAMPLE_BITS - 1))) ? RW'(2 ** (SAMPLE_BITS - 1)) : root;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (clr_cnt == PW'(MAX_WINDOW - 1)) state_next = S_IDLE;
      S_IDLE:   if (in_valid) state_next = S_SQ_OLD;
      S_SQ_OLD: state_next = S_SUB;
      S_SUB:    state_next = S_ADD;
      S_ADD:    state_next = S_DDIV;
      S_DDIV:   if (it_done) state_next = S_IDX;
      S_IDX:    state_next = S_MDIV;
      S_MDIV:   if (it_done) state_next = S_SQRT;
      S_SQRT:   if (it_done) state_next = S_DONE;
      S_DONE:   if (!out_valid || out_ready) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = pos;
    ram_wdata = cur.sample;
    ram_re    = 1'b0;
    ram_raddr = pos;
    ctl.start = 1'b0;
    ctl.op    = OP_DIV;
    ctl.steps = STEP_BITS'(DELAY_BITS);
    it_num    = XW'(cur.delay) << (XW - DELAY_BITS);
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        ram_re   = 1'b1;
      end
      S_SUB: begin
        ram_we = 1'b1;
      end
      S_ADD: begin
        ctl.start = 1'b1;
      end
      S_IDX: begin
        ram_re    = 1'b1;
        ram_raddr = idx;
        ctl.start = 1'b1;
        ctl.steps = STEP_BITS'(XW);
        it_num    = XW'(sum);
      end
      S_MDIV: begin
        ctl.start = it_done;
        ctl.op    = OP_SQRT;
        ctl.steps = STEP_BITS'(RW);
        it_num    = it_quot;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      pos        <= '0;
      sum        <= '0;
      window_len <= WINDOW_RESET;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        window_len <= cfg_data;
      end
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + PW'(1);
      end
      if (state == S_SUB) begin
        sum <= sum - SUM_W'(prod);
      end
      if (state == S_ADD) begin
        sum <= sum + SUM_W'(prod);
        pos <= pos_wrap;
      end
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item and result registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      cur <= in_data;
      len <= len_eff;
    end
    if (state == S_SQ_OLD || state == S_SUB) begin
      prod <= $unsigned(sq_full);
    end
    if (state == S_DDIV && it_done) begin
      dr <= it_rem;
    end
    if (state == S_DONE && (!out_valid || out_ready)) begin
      out_data.rms_value      <= RMS_BITS'(root_sat);
      out_data.delayed_sample <= $signed(ram_rdata);
    end
  end

  assign cfg_ready = 1'b1;

  swr_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_WINDOW)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  swr_iter #(
    .XW(XW),
    .LW(LW),
    .AW(AW)
  ) u_iter (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .num (it_num),
    .den (len),
    .done(it_done),
    .quot(it_quot),
    .rem (it_rem)
  );

`ifndef SYNTHESIS
  // the running sum always covers the square of the entry being replaced
  a_sum_no_underflow: assert property (@(posedge clk) disable iff (rst)
    state == S_SUB |-> sum >= SUM_W'(prod))
    else $error("sum of squares would underflow");

  // position stays inside the window once advanced
  a_pos_in_window: assert property (@(posedge clk) disable iff (rst)
    state == S_IDX |-> LW'(pos) < len)
    else $error("write position outside window");

  // delay remainder and read index stay below the window length
  a_idx_in_window: assert property (@(posedge clk) disable iff (rst)
    state == S_IDX |-> (dr < len) && (LW'(idx) < len))
    else $error("delayed read index outside window");

  // unit is started only from the add, index and mean-divide states
  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    ctl.start |-> (state == S_ADD || state == S_IDX || state == S_MDIV))
    else $error("shared unit started from wrong state");
`endif

endmodule

### tb/tb.sv
module tb;
  import swr_pkg::*;

  localparam int WIN_MAX = 1024;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 830;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_BITS-1:0] cfg_data = '0;

  sliding_window_rms #(.MAX_WINDOW(WIN_MAX)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [SAMPLE_BITS-1:0] ring_mirror [WIN_MAX];
  int unsigned wr_pos;
  longint unsigned energy_sum;
  int unsigned win_setting;

  out_item_t rms_expected [$];
  int errors = 0;
  int idle_cycles = 0;
  bit stim_done = 0;
  bit hold_off = 0;

  function automatic longint unsigned sample_square(logic [SAMPLE_BITS-1:0] s);
    longint signed v;
    v = longint'($signed(s));
    return longint'(v * v);
  endfunction

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // compute expected rms and delayed sample for one item
  function automatic out_item_t predict_rms(in_item_t it);
    int unsigned len;
    int unsigned p;
    int unsigned d;
    longint unsigned root;
    out_item_t r;
    len = (win_setting == 0) ? 1 : (win_setting > WIN_MAX ? WIN_MAX : win_setting);
    p = wr_pos;
    if (p >= WIN_MAX) p = 0;
    energy_sum = energy_sum - sample_square(ring_mirror[p]);
    ring_mirror[p] = it.sample;
    energy_sum = energy_sum + sample_square(it.sample);
    p++;
    if (p >= len) p = 0;
    wr_pos = p;
    root = isqrt(energy_sum / len);
    if (root > (64'd1 << (SAMPLE_BITS - 1))) root = 64'd1 << (SAMPLE_BITS - 1);
    d = it.delay % len;
    r.rms_value = root[RMS_BITS-1:0];
    r.delayed_sample = ring_mirror[(p + len - 1 - d) % len];
    return r;
  endfunction

  // random gap, mostly short, sometimes long
  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 45) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 120);
  endfunction

  // valid stays high straight into the next item when there is no gap
  task automatic send_item(in_item_t it);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rms_expected.push_back(predict_rms(it));
  endtask

  task automatic write_window(int unsigned v);
    cfg_valid <= 1'b1;
    cfg_data <= CFG_BITS'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    win_setting = v;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (rms_expected.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic in_item_t rand_item(bit extreme);
    in_item_t it;
    int k;
    k = $urandom_range(0, 3);
    if (extreme && k == 0) it.sample = 16'sh8000;
    else if (extreme && k == 1) it.sample = 16'sh7fff;
    else it.sample = SAMPLE_BITS'($urandom());
    it.delay = DELAY_BITS'($urandom());
    return it;
  endfunction

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_off) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) < 70);
    end
  end

  initial begin
    int c;
    wait (!rst);
    repeat (($urandom_range(0, 1) == 0) ? 1 : 0) @(posedge clk);
    wait (stim_done == 0 && rms_expected.size() > 0);
    hold_off = 1;
    for (c = 0; c < 400; c++) @(posedge clk);
    hold_off = 0;
  end

  // result checker
  always @(posedge clk) begin
    out_item_t e;
    if (!rst && out_valid && out_ready) begin
      if (rms_expected.size() == 0) begin
        $display("%0t unexpected result %h", $time, out_data);
        errors++;
      end else begin
        e = rms_expected.pop_front();
        if (out_data.rms_value !== e.rms_value) begin
          $display("%0t rms_value expected %0d actual %0d", $time, e.rms_value,
                   out_data.rms_value);
          errors++;
        end
        if (out_data.delayed_sample !== e.delayed_sample) begin
          $display("%0t delayed_sample expected %0d actual %0d", $time,
                   e.delayed_sample, out_data.delayed_sample);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [DELAY_BITS-1:0] delay;
    bit has_expect;
    logic [RMS_BITS-1:0] rms;
    logic signed [SAMPLE_BITS-1:0] dly;
  } stim_row_t;

  stim_row_t directed_rows [$];

  initial begin
    stim_row_t row;
    in_item_t it;
    out_item_t e;
    int i;
    int n;
    int wins [6];
    for (i = 0; i < WIN_MAX; i++) ring_mirror[i] = '0;
    wr_pos = 0;
    energy_sum = 0;
    win_setting = WINDOW_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed table at window length 1 so rms is read off directly
    write_window(1);
    directed_rows = '{
      '{16'sh0000, 10'd0, 1, 16'd0, 16'sh0000},
      '{16'sh7fff, 10'd0, 1, 16'd32767, 16'sh7fff},
      '{-16'sd32768, 10'd1023, 1, 16'd32768, -16'sd32768},
      '{-16'sd1, 10'd5, 1, 16'd1, -16'sd1},
      '{16'sd3, 10'd512, 1, 16'd3, 16'sd3}
    };
    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      it.sample = row.sample;
      it.delay = row.delay;
      e = predict_rms(it);
      if (row.has_expect && (e.rms_value !== row.rms || e.delayed_sample !== row.dly)) begin
        $display("%0t table row %0d expected %0d/%0d predictor %0d/%0d", $time, k,
                 row.rms, row.dly, e.rms_value, e.delayed_sample);
        errors++;
      end
      // undo predictor step: send_item recomputes it
      void'(rms_expected.size());
      wr_pos = 0;
      energy_sum = 0;
      for (i = 0; i < WIN_MAX; i++) ring_mirror[i] = '0;
      send_item(it);
    end
    drain();

    // small window, extremes and wrapping delays
    write_window(4);
    for (i = 0; i < 8; i++) begin
      it.sample = (i % 2) ? 16'sh7fff : -16'sd32768;
      it.delay = DELAY_BITS'(i * 3);
      send_item(it);
    end
    drain();
    // shrink with stale entries (saturation) through the zero setting
    write_window(0);
    for (i = 0; i < 6; i++) send_item(rand_item(1));
    drain();

    // random phases across settings
    wins = '{2047, 1024, 3, 37, 1, 600};
    n = 0;
    foreach (wins[w]) begin
      write_window(wins[w]);
      for (i = 0; i < N_RANDOM / 6; i++) begin
        send_item(rand_item($urandom_range(0, 3) == 0));
        n++;
      end
      drain();
    end
    stim_done = 1;
    drain();
    if (errors == 0 && rms_expected.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
sv/swr_pkg.sv
sv/swr_ram.sv
sv/swr_iter.sv
sv/sliding_window_rms.sv
tb/tb.sv
